// File: design/mi_pkg.sv
// ----------------------------------------------------------------------------
// mi_pkg
// Shared widths, types and saturation helper for the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
package mi_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * DATA_W;          // 2x2 minor products
  localparam int COF_W     = PROD_W + 1;          // cofactor, exact
  localparam int LO_W      = COF_W - DATA_W;      // low slice of a cofactor
  localparam int PLO_W     = DATA_W + LO_W + 1;   // row0 x low slice
  localparam int TERM_W    = DATA_W + COF_W;      // row0 x cofactor
  localparam int DET_W     = TERM_W + 2;          // sum of three terms
  localparam int SHIFT     = 2 * FRAC_BITS;       // numerator scale
  localparam int NUM_W     = COF_W + SHIFT;       // scaled numerator magnitude
  localparam int QB        = DATA_W + 1;          // quotient bits kept

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [PLO_W-1:0]  plo_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic        [DET_W-1:0]  mag_t;
  typedef logic        [QB-1:0]     quo_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // determinant output: arithmetic shift down by 2*FRAC_BITS, then saturate
  function automatic word_t sat_det(det_t v);
    det_t s;
    s = v >>> SHIFT;
    if ((&s[DET_W-1:DATA_W-1]) || !(|s[DET_W-1:DATA_W-1])) begin
      sat_det = s[DATA_W-1:0];
    end else if (s[DET_W-1]) begin
      sat_det = WORD_MIN;
    end else begin
      sat_det = WORD_MAX;
    end
  endfunction

endpackage

// File: design/mi_cofactor.sv
// ----------------------------------------------------------------------------
// mi_cofactor
// Two stages: the 18 minor products, then the signed 2x2 cofactors.
// ----------------------------------------------------------------------------
module mi_cofactor (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  mi_pkg::word_t    m [9],
  output logic             out_vld,
  output mi_pkg::cof_t     cof [9],
  output mi_pkg::word_t    row0 [3]
);

  mi_pkg::prod_t pa_nxt [9];
  mi_pkg::prod_t pb_nxt [9];
  mi_pkg::prod_t pa_r   [9];
  mi_pkg::prod_t pb_r   [9];
  mi_pkg::cof_t  cof_nxt [9];
  mi_pkg::cof_t  cof_r   [9];
  mi_pkg::word_t row0_s1_r [3];
  mi_pkg::word_t row0_s2_r [3];
  logic          vld1_r;
  logic          vld2_r;

  for (genvar k = 0; k < 9; k++) begin : g_cof
    localparam int I  = k / 3;
    localparam int J  = k % 3;
    localparam int R0 = (I == 0) ? 1 : 0;
    localparam int R1 = (I == 2) ? 1 : 2;
    localparam int C0 = (J == 0) ? 1 : 0;
    localparam int C1 = (J == 2) ? 1 : 2;
    mi_pkg::cof_t diff;

    assign pa_nxt[k] = m[R0*3+C0] * m[R1*3+C1];
    assign pb_nxt[k] = m[R0*3+C1] * m[R1*3+C0];
    assign diff = mi_pkg::cof_t'(pa_r[k]) - mi_pkg::cof_t'(pb_r[k]);

    if (((I + J) % 2) == 1) begin : g_neg
      assign cof_nxt[k] = -diff;
    end else begin : g_pos
      assign cof_nxt[k] = diff;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      pa_r[k]  <= pa_nxt[k];
      pb_r[k]  <= pb_nxt[k];
      cof_r[k] <= cof_nxt[k];
    end
    for (int k = 0; k < 3; k++) begin
      row0_s1_r[k] <= m[k];
      row0_s2_r[k] <= row0_s1_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  assign out_vld = vld2_r;
  assign cof     = cof_r;
  assign row0    = row0_s2_r;

endmodule

// File: design/mi_det.sv
// ----------------------------------------------------------------------------
// mi_det
// Three stages: split partial products, term assembly, three-way sum.
// Cofactors ride along for the divider.
// ----------------------------------------------------------------------------
module mi_det (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  mi_pkg::cof_t     cof_in [9],
  input  mi_pkg::word_t    row0 [3],
  output logic             out_vld,
  output mi_pkg::cof_t     cof_out [9],
  output mi_pkg::det_t     det
);

  mi_pkg::plo_t  plo_r  [3];
  mi_pkg::prod_t phi_r  [3];
  mi_pkg::term_t term_r [3];
  mi_pkg::det_t  det_r;
  mi_pkg::cof_t  cof3_r [9];
  mi_pkg::cof_t  cof4_r [9];
  mi_pkg::cof_t  cof5_r [9];
  logic [2:0]    vld_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      // cofactor split into an unsigned low slice and a signed high slice
      plo_r[k]  <= row0[k] * $signed({1'b0, cof_in[k][mi_pkg::LO_W-1:0]});
      phi_r[k]  <= row0[k] * $signed(cof_in[k][mi_pkg::COF_W-1:mi_pkg::LO_W]);
      term_r[k] <= (mi_pkg::term_t'(phi_r[k]) <<< mi_pkg::LO_W)
                   + mi_pkg::term_t'(plo_r[k]);
    end
    det_r <= mi_pkg::det_t'(term_r[0]) + mi_pkg::det_t'(term_r[1])
             + mi_pkg::det_t'(term_r[2]);
    for (int k = 0; k < 9; k++) begin
      cof3_r[k] <= cof_in[k];
      cof4_r[k] <= cof3_r[k];
      cof5_r[k] <= cof4_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  assign out_vld = vld_r[2];
  assign cof_out = cof5_r;
  assign det     = det_r;

endmodule

// File: design/mi_divide.sv
// ----------------------------------------------------------------------------
// mi_divide
// Nine restoring dividers in lockstep: one setup stage, one quotient bit per
// stage, then sign and saturation into the output registers.
// ----------------------------------------------------------------------------
module mi_divide (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  mi_pkg::cof_t     cof [9],
  input  mi_pkg::det_t     det,
  output logic             out_vld,
  output mi_pkg::word_t    inv [9],
  output mi_pkg::word_t    det_out,
  output logic             singular
);

  localparam int QB = mi_pkg::QB;
  localparam int DW = mi_pkg::DATA_W;

  mi_pkg::mag_t  rem_r  [QB+1][9];
  mi_pkg::quo_t  low_r  [QB+1][9];
  mi_pkg::quo_t  q_r    [QB+1][9];
  logic          ovf_r  [QB+1][9];
  logic          qneg_r [QB+1][9];
  mi_pkg::mag_t  dabs_r [QB+1];
  logic          dz_r   [QB+1];
  mi_pkg::word_t dsat_r [QB+1];
  logic [QB:0]   vld_r;

  mi_pkg::mag_t  rem_nxt [QB][9];
  mi_pkg::quo_t  low_nxt [QB][9];
  mi_pkg::quo_t  q_nxt   [QB][9];

  mi_pkg::mag_t  dabs0;
  mi_pkg::mag_t  rem0 [9];
  mi_pkg::quo_t  low0 [9];
  logic          cneg0 [9];

  mi_pkg::word_t inv_nxt [9];
  mi_pkg::word_t inv_r   [9];
  mi_pkg::word_t dout_r;
  logic          sing_r;
  logic          ovld_r;

  // setup: magnitudes, first partial remainder, quotient overflow check
  always_comb begin
    logic [mi_pkg::COF_W-1:0] cabs;
    logic [mi_pkg::NUM_W-1:0] nabs;
    dabs0 = det[mi_pkg::DET_W-1] ? mi_pkg::mag_t'(-det) : mi_pkg::mag_t'(det);
    for (int l = 0; l < 9; l++) begin
      cneg0[l] = cof[l][mi_pkg::COF_W-1];
      cabs     = cneg0[l] ? (-cof[l]) : cof[l];
      nabs     = {cabs, {mi_pkg::SHIFT{1'b0}}};
      rem0[l]  = mi_pkg::mag_t'(nabs[mi_pkg::NUM_W-1:QB]);
      low0[l]  = nabs[QB-1:0];
    end
  end

  always_comb begin
    logic [mi_pkg::DET_W:0] rem_sh;
    for (int s = 0; s < QB; s++) begin
      for (int l = 0; l < 9; l++) begin
        rem_sh = {rem_r[s][l], low_r[s][l][QB-1]};
        low_nxt[s][l] = {low_r[s][l][QB-2:0], 1'b0};
        if (rem_sh >= {1'b0, dabs_r[s]}) begin
          rem_nxt[s][l] = mi_pkg::mag_t'(rem_sh - {1'b0, dabs_r[s]});
          q_nxt[s][l]   = {q_r[s][l][QB-2:0], 1'b1};
        end else begin
          rem_nxt[s][l] = rem_sh[mi_pkg::DET_W-1:0];
          q_nxt[s][l]   = {q_r[s][l][QB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    dabs_r[0] <= dabs0;
    dz_r[0]   <= (det == '0);
    dsat_r[0] <= mi_pkg::sat_det(det);
    for (int l = 0; l < 9; l++) begin
      rem_r[0][l]  <= rem0[l];
      low_r[0][l]  <= low0[l];
      q_r[0][l]    <= '0;
      ovf_r[0][l]  <= (rem0[l] >= dabs0);
      qneg_r[0][l] <= cneg0[l] ^ det[mi_pkg::DET_W-1];
    end
    for (int s = 0; s < QB; s++) begin
      dabs_r[s+1] <= dabs_r[s];
      dz_r[s+1]   <= dz_r[s];
      dsat_r[s+1] <= dsat_r[s];
      for (int l = 0; l < 9; l++) begin
        rem_r[s+1][l]  <= rem_nxt[s][l];
        low_r[s+1][l]  <= low_nxt[s][l];
        q_r[s+1][l]    <= q_nxt[s][l];
        ovf_r[s+1][l]  <= ovf_r[s][l];
        qneg_r[s+1][l] <= qneg_r[s][l];
      end
    end
  end

  // sign and saturate the quotients
  always_comb begin
    mi_pkg::quo_t q;
    for (int l = 0; l < 9; l++) begin
      q = q_r[QB][l];
      if (dz_r[QB]) begin
        inv_nxt[l] = '0;
      end else if (qneg_r[QB][l]) begin
        if (ovf_r[QB][l] || q[QB-1] || (q[DW-1] && (|q[DW-2:0]))) begin
          inv_nxt[l] = mi_pkg::WORD_MIN;
        end else begin
          inv_nxt[l] = -mi_pkg::word_t'(q[DW-1:0]);
        end
      end else begin
        if (ovf_r[QB][l] || (|q[QB-1:DW-1])) begin
          inv_nxt[l] = mi_pkg::WORD_MAX;
        end else begin
          inv_nxt[l] = mi_pkg::word_t'(q[DW-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 9; l++) begin
      inv_r[l] <= inv_nxt[l];
    end
    dout_r <= dz_r[QB] ? '0 : dsat_r[QB];
    sing_r <= dz_r[QB];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      vld_r  <= {vld_r[QB-1:0], in_vld};
      ovld_r <= vld_r[QB];
    end
  end

  assign out_vld  = ovld_r;
  assign inv      = inv_r;
  assign det_out  = dout_r;
  assign singular = sing_r;

endmodule

// File: design/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// 3x3 inverse by the adjugate in signed Q16.16, with determinant and a
// singular flag; fully pipelined.
//
//   channel  | ports                            | handshake
//   ---------+----------------------------------+---------------------------
//   input    | in_m11 .. in_m33                 | start & !busy
//   result   | out_inv11 .. out_inv33,          | out_valid, one cycle,
//            | out_determinant, out_singular    | no back-pressure
//
// One transaction per cycle; each result passes through 2 cofactor stages,
// 3 determinant stages, divider setup, 33 quotient-bit stages and the output
// register. The 33-stage restoring divider sets the latency.
// Synchronous active-low reset clears all valid bits. busy stays low: the
// receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module matrix3x3_inverse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  in_m11,
  input  logic signed [31:0]  in_m12,
  input  logic signed [31:0]  in_m13,
  input  logic signed [31:0]  in_m21,
  input  logic signed [31:0]  in_m22,
  input  logic signed [31:0]  in_m23,
  input  logic signed [31:0]  in_m31,
  input  logic signed [31:0]  in_m32,
  input  logic signed [31:0]  in_m33,
  output logic                out_valid,
  output logic signed [31:0]  out_inv11,
  output logic signed [31:0]  out_inv12,
  output logic signed [31:0]  out_inv13,
  output logic signed [31:0]  out_inv21,
  output logic signed [31:0]  out_inv22,
  output logic signed [31:0]  out_inv23,
  output logic signed [31:0]  out_inv31,
  output logic signed [31:0]  out_inv32,
  output logic signed [31:0]  out_inv33,
  output logic signed [31:0]  out_determinant,
  output logic                out_singular
);

  mi_pkg::word_t m [9];
  mi_pkg::cof_t  cof_a [9];
  mi_pkg::cof_t  cof_b [9];
  mi_pkg::word_t row0 [3];
  mi_pkg::det_t  det;
  mi_pkg::word_t inv [9];
  logic          vld_a;
  logic          vld_b;
  logic          accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign m[0] = in_m11;
  assign m[1] = in_m12;
  assign m[2] = in_m13;
  assign m[3] = in_m21;
  assign m[4] = in_m22;
  assign m[5] = in_m23;
  assign m[6] = in_m31;
  assign m[7] = in_m32;
  assign m[8] = in_m33;

  mi_cofactor u_cofactor (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (accept),
    .m       (m),
    .out_vld (vld_a),
    .cof     (cof_a),
    .row0    (row0)
  );

  mi_det u_det (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld_a),
    .cof_in  (cof_a),
    .row0    (row0),
    .out_vld (vld_b),
    .cof_out (cof_b),
    .det     (det)
  );

  mi_divide u_divide (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld_b),
    .cof      (cof_b),
    .det      (det),
    .out_vld  (out_valid),
    .inv      (inv),
    .det_out  (out_determinant),
    .singular (out_singular)
  );

  // adjugate is the transposed cofactor matrix
  assign out_inv11 = inv[0];
  assign out_inv12 = inv[3];
  assign out_inv13 = inv[6];
  assign out_inv21 = inv[1];
  assign out_inv22 = inv[4];
  assign out_inv23 = inv[7];
  assign out_inv31 = inv[2];
  assign out_inv32 = inv[5];
  assign out_inv33 = inv[8];

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for matrix3x3_inverse. It sends directed and random
// 3x3 Q16.16 matrices with random gaps and checks every inverse, determinant
// and singular flag against a full-width adjugate computation.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    mi_pkg::word_t inv [9];
    mi_pkg::word_t det;
    logic          sing;
  } inverse_t;

  class inverse_scoreboard;
    inverse_t expected_q[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function mi_pkg::word_t clamp_word(wide_t v);
      wide_t hi, lo;
      hi = mi_pkg::WORD_MAX;
      lo = mi_pkg::WORD_MIN;
      if (v > hi) return mi_pkg::WORD_MAX;
      if (v < lo) return mi_pkg::WORD_MIN;
      return v[mi_pkg::DATA_W-1:0];
    endfunction

    function inverse_t invert_adjugate(mi_pkg::word_t m [9]);
      inverse_t r;
      wide_t    a [3][3];
      wide_t    cof [3][3];
      wide_t    det, t;
      int       r0, r1, c0, c1;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) a[i][j] = m[i*3+j];
      for (int i = 0; i < 3; i++) begin
        r0 = (i == 0) ? 1 : 0;
        r1 = (i == 2) ? 1 : 2;
        for (int j = 0; j < 3; j++) begin
          c0 = (j == 0) ? 1 : 0;
          c1 = (j == 2) ? 1 : 2;
          t = a[r0][c0] * a[r1][c1] - a[r0][c1] * a[r1][c0];
          cof[i][j] = ((i + j) % 2 == 1) ? -t : t;
        end
      end
      det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
      if (det == 0) begin
        foreach (r.inv[k]) r.inv[k] = '0;
        r.det  = '0;
        r.sing = 1'b1;
      end else begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) begin
            t = cof[j][i] <<< mi_pkg::SHIFT;
            r.inv[i*3+j] = clamp_word(t / det);
          end
        r.det  = clamp_word(det >>> mi_pkg::SHIFT);
        r.sing = 1'b0;
      end
      return r;
    endfunction

    function void note_matrix(mi_pkg::word_t m [9]);
      expected_q.push_back(invert_adjugate(m));
    endfunction

    function void check_result(inverse_t got);
      inverse_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, det %h singular %b", $time, got.det, got.sing);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      for (int k = 0; k < 9; k++)
        if (got.inv[k] !== exp_r.inv[k]) begin
          $display("%0t: inv%0d%0d expected %h actual %h", $time, k/3 + 1, k%3 + 1,
                   exp_r.inv[k], got.inv[k]);
          errors++;
        end
      if (got.det !== exp_r.det) begin
        $display("%0t: determinant expected %h actual %h", $time, exp_r.det, got.det);
        errors++;
      end
      if (got.sing !== exp_r.sing) begin
        $display("%0t: singular expected %b actual %b", $time, exp_r.sing, got.sing);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  localparam mi_pkg::word_t ONE = 32'sh0001_0000;
  localparam int            CYCLE_LIMIT = 200000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  mi_pkg::word_t in_m [9];
  logic          out_valid;
  mi_pkg::word_t out_inv [9];
  mi_pkg::word_t out_determinant;
  logic          out_singular;
  int            cycles = 0;
  int            item_cnt = 0;

  inverse_scoreboard sb = new();

  initial foreach (in_m[k]) in_m[k] = '0;

  always #4 clk = ~clk;

  matrix3x3_inverse dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_m11(in_m[0]), .in_m12(in_m[1]), .in_m13(in_m[2]),
    .in_m21(in_m[3]), .in_m22(in_m[4]), .in_m23(in_m[5]),
    .in_m31(in_m[6]), .in_m32(in_m[7]), .in_m33(in_m[8]),
    .out_valid(out_valid),
    .out_inv11(out_inv[0]), .out_inv12(out_inv[1]), .out_inv13(out_inv[2]),
    .out_inv21(out_inv[3]), .out_inv22(out_inv[4]), .out_inv23(out_inv[5]),
    .out_inv31(out_inv[6]), .out_inv32(out_inv[7]), .out_inv33(out_inv[8]),
    .out_determinant(out_determinant), .out_singular(out_singular)
  );

  // monitor: samples pre-edge values of both channels
  always @(posedge clk) begin
    inverse_t got;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** matrix3x3_inverse: FAILED **");
      $finish;
    end
    if (rst_n) begin
      if (out_valid) begin
        got.inv  = out_inv;
        got.det  = out_determinant;
        got.sing = out_singular;
        sb.check_result(got);
      end
      if (start && !busy) sb.note_matrix(in_m);
    end
  end

  task automatic send_matrix(input mi_pkg::word_t m [9]);
    for (int k = 0; k < 9; k++) in_m[k] <= m[k];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    item_cnt++;
    // random gaps, except for a quiet stretch in the middle
    if ((item_cnt < 250 || item_cnt > 450) && $urandom_range(0, 99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic mi_pkg::word_t small_entry();
    logic [19:0] raw;
    raw = 20'($urandom);
    return mi_pkg::word_t'($signed(raw));
  endfunction

  task automatic send_diag(input mi_pkg::word_t d1, input mi_pkg::word_t d2,
                           input mi_pkg::word_t d3);
    mi_pkg::word_t m [9];
    foreach (m[k]) m[k] = '0;
    m[0] = d1;
    m[4] = d2;
    m[8] = d3;
    send_matrix(m);
  endtask

  task automatic send_fill(input mi_pkg::word_t v);
    mi_pkg::word_t m [9];
    foreach (m[k]) m[k] = v;
    send_matrix(m);
  endtask

  task automatic send_random();
    mi_pkg::word_t m [9];
    int            sel;
    sel = $urandom_range(0, 99);
    for (int k = 0; k < 9; k++) begin
      if (sel < 30) m[k] = $urandom;
      else m[k] = small_entry();
    end
    if (sel >= 60 && sel < 75) begin
      // rank deficient: repeat or negate a row, or clear a column
      case ($urandom_range(0, 2))
        0: for (int j = 0; j < 3; j++) m[6+j] = m[j];
        1: for (int j = 0; j < 3; j++) m[3+j] = -m[j];
        default: for (int i = 0; i < 3; i++) m[i*3+1] = '0;
      endcase
    end else if (sel >= 75) begin
      // well conditioned: identity plus noise
      for (int k = 0; k < 9; k++)
        m[k] = ((k % 4 == 0) ? ONE : '0) + mi_pkg::word_t'($signed(16'($urandom)));
    end
    send_matrix(m);
  endtask

  initial begin
    mi_pkg::word_t m [9];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_diag(ONE, ONE, ONE);
    send_diag(-ONE, -ONE, -ONE);
    send_diag(2 * ONE, ONE / 2, -4 * ONE);
    send_diag(32'sd1, 32'sd1, 32'sd1);        // tiny determinant
    send_diag(mi_pkg::WORD_MAX, mi_pkg::WORD_MAX, mi_pkg::WORD_MAX);
    send_diag(mi_pkg::WORD_MIN, mi_pkg::WORD_MIN, mi_pkg::WORD_MIN);
    send_diag(mi_pkg::WORD_MIN, mi_pkg::WORD_MAX, -ONE);
    send_fill('0);
    send_fill(mi_pkg::WORD_MAX);
    send_fill(mi_pkg::WORD_MIN);
    send_fill(-32'sd1);
    m = '{ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 10*ONE};
    send_matrix(m);
    m = '{ONE, 2*ONE, 3*ONE, 2*ONE, 4*ONE, 6*ONE, -ONE, ONE, 0};
    send_matrix(m);
    m = '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0};    // permutation
    send_matrix(m);
    m = '{mi_pkg::WORD_MAX, mi_pkg::WORD_MIN, 32'sd1, -32'sd1, mi_pkg::WORD_MAX, 0,
          mi_pkg::WORD_MIN, 0, mi_pkg::WORD_MAX};
    send_matrix(m);
    m = '{32'sd3, 0, 0, 0, 32'sd5, 0, 0, 0, -32'sd7};
    send_matrix(m);

    // hold off until the pipeline has drained
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);

    repeat (700) send_random();

    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** matrix3x3_inverse: PASSED **");
    end else begin
      $display("** matrix3x3_inverse: FAILED **");
    end
    $finish;
  end

endmodule
